/* rtl/scoa_pkg.sv */
// package: constants, types and helpers for the size class object allocator
package scoa_pkg;

    localparam int unsigned NumClasses   = 6;
    localparam int unsigned LocalDepth   = 128;
    localparam int unsigned RingDepth    = 256;
    localparam int unsigned CentralDepth = 256;
    localparam int unsigned NumBlocks    = 4;
    localparam int unsigned BlockLog2    = 20;

    localparam int unsigned ClsW   = 3;
    localparam int unsigned AddrW  = 22;
    localparam int unsigned LcntW  = $clog2(LocalDepth + 1);
    localparam int unsigned LidxW  = $clog2(LocalDepth);
    localparam int unsigned RptrW  = $clog2(2 * RingDepth);
    localparam int unsigned RidxW  = $clog2(RingDepth);
    localparam int unsigned CcntW  = $clog2(CentralDepth + 1);
    localparam int unsigned CidxW  = $clog2(CentralDepth);
    localparam int unsigned OffW   = BlockLog2 + 1;
    localparam int unsigned BlkW   = $clog2(NumBlocks + 1);
    localparam int unsigned CfgW   = 7;

    typedef logic [ClsW-1:0]  t_cls;
    typedef logic [AddrW-1:0] t_addr;

    typedef enum logic [2:0] {
        ST_LOCAL        = 3'd0,
        ST_CENTRAL      = 3'd1,
        ST_BUMP         = 3'd2,
        ST_FREED_LOCAL  = 3'd3,
        ST_FREED_RING   = 3'd4,
        ST_FREE_DROPPED = 3'd5,
        ST_OUT_OF_ARENA = 3'd6,
        ST_NOT_SMALL    = 3'd7
    } t_status;

    localparam logic CFG_SPILL = 1'b0;
    localparam logic CFG_DRAIN = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_DRAIN_RD,
        S_DRAIN_WR,
        S_POP,
        S_BUMP,
        S_OUT
    } t_state;

    // bump request and answer between control and bump unit
    typedef struct packed {
        logic       go;
        logic [3:0] align_log2;
        t_cls       cls;
    } t_bump_req;

    typedef struct packed {
        logic  ok;
        t_addr address;
    } t_bump_rsp;

endpackage

/* rtl/scoa_bump.sv */
// bump pointer over the arena blocks, one step per request
module scoa_bump (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  scoa_pkg::t_bump_req i_req,
    output scoa_pkg::t_bump_rsp o_rsp
);
    import scoa_pkg::*;

    logic [OffW-1:0] r_offset, n_offset;
    logic [BlkW-1:0] r_block,  n_block;

    logic [3:0]      w_alog;
    logic [OffW:0]   w_amask, w_size, w_off, w_end;
    logic [OffW:0]   w_csize;
    logic [BlkW-1:0] w_next_blk;

    // effective alignment at least 16 bytes
    always_comb begin
        w_alog   = (i_req.align_log2 < 4'd4) ? 4'd4 : i_req.align_log2;
        w_amask  = (OffW+1)'((1 << w_alog) - 1);
        w_csize  = (OffW+1)'(8) << i_req.cls;
        w_size   = (w_csize + w_amask) & ~w_amask;
        w_off    = ({1'b0, r_offset} + w_amask) & ~w_amask;
        w_end    = w_off + w_size;
        w_next_blk = r_block + 1'b1;
    end

    // carve or advance block
    always_comb begin
        n_offset      = r_offset;
        n_block       = r_block;
        o_rsp.ok      = 1'b0;
        o_rsp.address = '0;
        if (r_block < BlkW'(NumBlocks) && w_size <= (OffW+1)'(1 << BlockLog2)) begin
            if (w_end <= (OffW+1)'(1 << BlockLog2)) begin
                o_rsp.ok      = 1'b1;
                o_rsp.address = AddrW'(({{(32-BlkW){1'b0}}, r_block} << BlockLog2)
                                + 32'(w_off));
                n_offset      = OffW'(w_end);
            end else begin
                n_block  = w_next_blk;
                n_offset = OffW'(w_off);
                if (w_next_blk < BlkW'(NumBlocks)) begin
                    o_rsp.ok      = 1'b1;
                    o_rsp.address = AddrW'({{(32-BlkW){1'b0}}, w_next_blk} << BlockLog2);
                    n_offset      = OffW'(w_size);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_block  <= '0;
        end else if (i_req.go) begin
            r_offset <= n_offset;
            r_block  <= n_block;
        end
    end

    ap_blk_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_block >= $past(r_block)) else $error("bump block went back");
    ap_blk_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_block <= BlkW'(NumBlocks)) else $error("bump block beyond count");
    ap_off_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_offset <= OffW'(1 << BlockLog2)) else $error("bump offset beyond block");
endmodule

/* rtl/scoa_mem.sv */
// the three address stores, each one write and one registered read
module scoa_mem (
    input  logic                                         i_clk,
    input  logic                                         i_l_we,
    input  logic [scoa_pkg::ClsW+scoa_pkg::LidxW-1:0]    i_l_addr,
    input  scoa_pkg::t_addr                              i_l_wdata,
    output scoa_pkg::t_addr                              o_l_rdata,
    input  logic                                         i_r_we,
    input  logic [scoa_pkg::ClsW+scoa_pkg::RidxW-1:0]    i_r_addr,
    input  scoa_pkg::t_addr                              i_r_wdata,
    output scoa_pkg::t_addr                              o_r_rdata,
    input  logic                                         i_c_we,
    input  logic [scoa_pkg::ClsW+scoa_pkg::CidxW-1:0]    i_c_addr,
    input  scoa_pkg::t_addr                              i_c_wdata,
    output scoa_pkg::t_addr                              o_c_rdata
);
    import scoa_pkg::*;

    localparam int unsigned LW = ClsW + LidxW;
    localparam int unsigned RW = ClsW + RidxW;
    localparam int unsigned CW = ClsW + CidxW;

    t_addr r_local   [0:(1<<LW)-1];
    t_addr r_ring    [0:(1<<RW)-1];
    t_addr r_central [0:(1<<CW)-1];

    // local stack
    always_ff @(posedge i_clk) begin
        if (i_l_we) r_local[i_l_addr] <= i_l_wdata;
        o_l_rdata <= r_local[i_l_addr];
    end
    // return ring
    always_ff @(posedge i_clk) begin
        if (i_r_we) r_ring[i_r_addr] <= i_r_wdata;
        o_r_rdata <= r_ring[i_r_addr];
    end
    // central stack
    always_ff @(posedge i_clk) begin
        if (i_c_we) r_central[i_c_addr] <= i_c_wdata;
        o_c_rdata <= r_central[i_c_addr];
    end
endmodule

/* rtl/size_class_object_allocator.sv */
// top level: request decode, per-class counters, sequencer and output register
// One request at a time. A free, a not-small request and an allocate from the local
// stack pass through the read and output states; a bump allocate passes through the
// read and bump states. An allocate served from the central stack first moves ring
// words into it while the ring holds any and the central stack has room (one ring read,
// one central write each, at most as many as the drain limit sets), then passes through
// the read, pop and output states. The output register holds the result until taken;
// the next request is accepted the cycle after it has been taken. All address stores are
// single-port synchronous memories; per-class counters sit in flip-flops.
module size_class_object_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // size_bytes, align_log2, free_address, pad
    input  logic [0:0]  s_axis_tuser,  // func
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // address, size_class, pad
    output logic [2:0]  m_axis_tuser   // status
);
    import scoa_pkg::*;

    t_state r_state, n_state;
    logic [CfgW-1:0] r_spill, r_drain;

    logic [LcntW-1:0] r_lcnt [NumClasses];
    logic [RptrW-1:0] r_rhead [NumClasses];
    logic [RptrW-1:0] r_rtail [NumClasses];
    logic [CcntW-1:0] r_ccnt [NumClasses];

    logic        r_func;
    logic [3:0]  r_alog;
    t_addr       r_faddr;
    t_cls        r_cls;
    logic        r_small;
    logic [CfgW-1:0] r_moved;
    t_addr       r_addr;
    t_status     r_status;
    logic        r_oval;

    t_addr w_lrd, w_rrd, w_crd;
    logic w_lwe, w_rwe, w_cwe;
    logic [ClsW+LidxW-1:0] w_la;
    logic [ClsW+RidxW-1:0] w_ra;
    logic [ClsW+CidxW-1:0] w_ca;
    t_addr w_lwd, w_rwd;
    t_bump_req w_breq;
    t_bump_rsp w_brsp;

    // input decode: rounded size and class
    logic [15:0] w_size_in;
    logic [3:0]  w_alog_in;
    logic [16:0] w_amask, w_rsize;
    logic        w_small_in;
    t_cls        w_cls_in;
    always_comb begin
        w_size_in = s_axis_tdata[15:0];
        w_alog_in = s_axis_tdata[19:16];
        w_amask   = 17'((17'd1 << w_alog_in) - 17'd1);
        w_rsize   = (w_alog_in > 4'd4) ? (({1'b0, w_size_in} + w_amask) & ~w_amask)
                                        : {1'b0, w_size_in};
        w_small_in = w_rsize <= 17'd256;
        w_cls_in  = ClsW'(NumClasses - 1);
        for (int i = NumClasses - 2; i >= 0; i--) begin
            if ((17'd8 << i) >= w_rsize) w_cls_in = ClsW'(i);
        end
    end

    logic w_acc;
    assign s_axis_tready = (r_state == S_IDLE) && !r_oval;
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // selected class views
    logic [LcntW-1:0] w_lc;
    logic [RptrW-1:0] w_rh, w_rt, w_fill;
    logic [CcntW-1:0] w_cc;
    logic w_spill, w_ring_full, w_drain_go;
    always_comb begin
        w_lc   = r_lcnt[r_cls];
        w_rh   = r_rhead[r_cls];
        w_rt   = r_rtail[r_cls];
        w_cc   = r_ccnt[r_cls];
        w_fill = w_rt - w_rh;
        w_spill = ({1'b0, w_lc} > (LcntW+1)'(r_spill)) || (w_lc >= LcntW'(LocalDepth));
        w_ring_full = w_fill >= RptrW'(RingDepth);
        w_drain_go  = (r_moved < r_drain) && (w_fill != '0)
                      && (w_cc < CcntW'(CentralDepth));
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (w_acc) n_state = S_READ;
            S_READ: begin
                if (!r_small || r_func || w_lc != '0) n_state = S_OUT;
                else if (w_drain_go) n_state = S_DRAIN_RD;
                else if (w_cc != '0) n_state = S_POP;
                else n_state = S_BUMP;
            end
            S_DRAIN_RD: n_state = S_DRAIN_WR;
            S_DRAIN_WR: n_state = S_READ;
            S_POP:      n_state = S_OUT;
            S_BUMP:     n_state = S_IDLE;
            S_OUT:      n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // memory control outputs
    always_comb begin
        w_lwe = 1'b0; w_rwe = 1'b0; w_cwe = 1'b0;
        w_la  = {r_cls, LidxW'(w_lc - 1'b1)};
        w_ra  = {r_cls, w_rh[RidxW-1:0]};
        w_ca  = {r_cls, CidxW'(w_cc - 1'b1)};
        w_lwd = r_faddr;
        w_rwd = r_faddr;
        w_breq.go = 1'b0;
        w_breq.align_log2 = r_alog;
        w_breq.cls = r_cls;
        unique case (r_state)
            S_READ: begin
                if (r_small && r_func) begin
                    if (w_spill) begin
                        w_ra  = {r_cls, w_rt[RidxW-1:0]};
                        w_rwe = !w_ring_full;
                    end else begin
                        w_la  = {r_cls, w_lc[LidxW-1:0]};
                        w_lwe = 1'b1;
                    end
                end
            end
            S_DRAIN_WR: begin
                w_ca  = {r_cls, w_cc[CidxW-1:0]};
                w_cwe = 1'b1;
            end
            S_BUMP:  w_breq.go = 1'b1;
            default: ;
        endcase
    end

    scoa_mem u_mem (
        .i_clk(i_clk),
        .i_l_we(w_lwe), .i_l_addr(w_la), .i_l_wdata(w_lwd), .o_l_rdata(w_lrd),
        .i_r_we(w_rwe), .i_r_addr(w_ra), .i_r_wdata(w_rwd), .o_r_rdata(w_rrd),
        .i_c_we(w_cwe), .i_c_addr(w_ca), .i_c_wdata(w_rrd), .o_c_rdata(w_crd)
    );

    scoa_bump u_bump (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_breq), .o_rsp(w_brsp));

    // request capture
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_func  <= s_axis_tuser[0];
            r_alog  <= w_alog_in;
            r_faddr <= s_axis_tdata[41:20];
            r_cls   <= w_small_in ? w_cls_in : '0;
            r_small <= w_small_in;
        end
    end

    // counters, config, result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_spill  <= CfgW'(64);
            r_drain  <= CfgW'(16);
            r_oval   <= 1'b0;
            r_moved  <= '0;
            for (int i = 0; i < NumClasses; i++) begin
                r_lcnt[i]  <= '0;
                r_rhead[i] <= '0;
                r_rtail[i] <= '0;
                r_ccnt[i]  <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_SPILL) r_spill <= i_cfg_data;
                else                          r_drain <= i_cfg_data;
            end
            if (m_axis_tvalid && m_axis_tready) r_oval <= 1'b0;
            if (w_acc) r_moved <= '0;
            unique case (r_state)
                S_READ: begin
                    r_addr <= '0;
                    if (!r_small) begin
                        r_status <= ST_NOT_SMALL;
                    end else if (r_func) begin
                        if (!w_spill) begin
                            r_lcnt[r_cls] <= w_lc + 1'b1;
                            r_status <= ST_FREED_LOCAL;
                        end else if (w_ring_full) begin
                            r_status <= ST_FREE_DROPPED;
                        end else begin
                            r_rtail[r_cls] <= w_rt + 1'b1;
                            r_status <= ST_FREED_RING;
                        end
                    end else if (w_lc != '0) begin
                        r_lcnt[r_cls] <= w_lc - 1'b1;
                        r_status <= ST_LOCAL;
                    end else if (!w_drain_go && w_cc != '0) begin
                        r_ccnt[r_cls] <= w_cc - 1'b1;
                        r_status <= ST_CENTRAL;
                    end
                end
                S_DRAIN_WR: begin
                    r_ccnt[r_cls]  <= w_cc + 1'b1;
                    r_rhead[r_cls] <= w_rh + 1'b1;
                    r_moved        <= r_moved + 1'b1;
                end
                // central word read at the pop address is valid only in this cycle
                S_POP: r_addr <= w_crd;
                S_BUMP: begin
                    r_addr   <= w_brsp.address;
                    r_status <= w_brsp.ok ? ST_BUMP : ST_OUT_OF_ARENA;
                    r_oval   <= 1'b1;
                end
                S_OUT: begin
                    if (r_status == ST_LOCAL) r_addr <= w_lrd;
                    r_oval <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // pop read address for central was set at S_READ via w_ca (cc-1); local via w_la
    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata  = {7'd0, r_cls, r_addr};
    assign m_axis_tuser  = r_status;

    ap_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oval |-> !s_axis_tready) else $error("accepting with result pending");
    ap_drain_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DRAIN_RD |-> r_moved < r_drain) else $error("drain over limit");
    ap_hit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_POP |=> r_state == S_OUT) else $error("pop not followed by output");
endmodule
